### design/twt_pkg.sv
package twt_pkg;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CADDR_W = 11;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 5;

  // default geometry of the screen store
  localparam int DEF_SCREEN_COLS = 80;
  localparam int DEF_SCREEN_ROWS = 25;
  localparam int DEF_TAB_STOP    = 4;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'd32;
  localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;

  // register reset values
  localparam logic             RST_ENABLED = 1'b1;
  localparam logic [ROW_W-1:0] RST_TOP     = 5'd2;
  localparam logic [COL_W-1:0] RST_LEFT    = 7'd0;
  localparam logic [COL_W-1:0] RST_WIDTH   = 7'd80;
  localparam logic [ROW_W-1:0] RST_HEIGHT  = 5'd23;

  typedef enum logic [OP_W-1:0] {
    OP_PUT_CURSOR,
    OP_PUT_AT,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    REG_ENABLED,
    REG_TOP,
    REG_LEFT,
    REG_WIDTH,
    REG_HEIGHT
  } reg_idx_t;

  typedef enum logic [1:0] {
    CH_BS,
    CH_TAB,
    CH_NL,
    CH_PRINT
  } ch_kind_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_BACK,
    CUR_NEWLINE,
    CUR_ADVANCE,
    CUR_WRAP,
    CUR_HOME
  } cur_op_t;

  typedef enum logic [1:0] {
    WSRC_CHAR,
    WSRC_BLANK,
    WSRC_MEMQ
  } wsrc_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CHAR,
    ST_TAB,
    ST_WRAP,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_BLANK,
    ST_WCLR,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             enabled;
    logic [ROW_W-1:0] top_row;
    logic [COL_W-1:0] left_col;
    logic [COL_W-1:0] width;
    logic [ROW_W-1:0] height;
  } twt_cfg_t;

  typedef struct packed {
    logic    accept;
    logic    init_wr;
    cur_op_t cur_op;
    logic    wr_en;
    logic    wr_at_sweep;
    wsrc_t   wr_src;
    logic    rd_en;
    logic    rd_at_target;
    logic    sweep_start;
    logic    sweep_step;
    logic    rd_capture;
    logic    out_load;
  } twt_cmd_t;

  typedef struct packed {
    op_t      op;
    logic     enabled;
    ch_kind_t ch_kind;
    logic     tab_more;
    logic     row_over;
    logic     one_row;
    logic     last_col;
    logic     last_copy_row;
    logic     last_row;
    logic     rd_in_window;
    logic     init_last;
  } twt_status_t;

  // bit i set when column i is a tab stop
  function automatic logic [2**COL_W-1:0] tab_mask(input int ts);
    logic [2**COL_W-1:0] m;
    int                  k;
    m = '0;
    k = 0;
    for (int i = 0; i < 2**COL_W; i++) begin
      m[i] = (k == 0);
      k    = (k == ts - 1) ? 0 : k + 1;
    end
    return m;
  endfunction

endpackage

### design/twt_ctrl.sv
module twt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  twt_pkg::twt_status_t status,
  output twt_pkg::twt_cmd_t    cmd
);
  import twt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.cur_op    = CUR_HOLD;
    cmd.wr_src    = WSRC_CHAR;
    case (state_r)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (status.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.op)
          OP_PUT_CURSOR, OP_PUT_AT: begin
            state_nxt = status.enabled ? ST_CHAR : ST_DONE;
          end
          OP_CLEAR: begin
            if (status.enabled) begin
              cmd.sweep_start = 1'b1;
              state_nxt       = ST_WCLR;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          OP_READ: begin
            if (status.rd_in_window) begin
              cmd.rd_en        = 1'b1;
              cmd.rd_at_target = 1'b1;
              state_nxt        = ST_RD_WAIT;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_CHAR: begin
        case (status.ch_kind)
          CH_BS: begin
            cmd.cur_op = CUR_BACK;
            state_nxt  = ST_WRAP;
          end
          CH_NL: begin
            cmd.cur_op = CUR_NEWLINE;
            state_nxt  = ST_WRAP;
          end
          CH_TAB: state_nxt = ST_TAB;
          default: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WSRC_CHAR;
            cmd.cur_op = CUR_ADVANCE;
            state_nxt  = ST_WRAP;
          end
        endcase
      end
      ST_TAB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WSRC_BLANK;
        cmd.cur_op = CUR_ADVANCE;
        if (!status.tab_more) state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.cur_op = CUR_WRAP;
        if (status.row_over) begin
          cmd.sweep_start = 1'b1;
          state_nxt       = status.one_row ? ST_BLANK : ST_SCR_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCR_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_at_sweep = 1'b1;
        cmd.wr_src      = WSRC_MEMQ;
        cmd.sweep_step  = 1'b1;
        state_nxt = (status.last_col && status.last_copy_row) ? ST_BLANK : ST_SCR_RD;
      end
      ST_BLANK: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_at_sweep = 1'b1;
        cmd.wr_src      = WSRC_BLANK;
        cmd.sweep_step  = 1'b1;
        if (status.last_col) state_nxt = ST_DONE;
      end
      ST_WCLR: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_at_sweep = 1'b1;
        cmd.wr_src      = WSRC_BLANK;
        cmd.sweep_step  = 1'b1;
        if (status.last_col && status.last_row) begin
          cmd.cur_op = CUR_HOME;
          state_nxt  = ST_DONE;
        end
      end
      ST_RD_WAIT: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### design/twt_dp.sv
module twt_dp #(
  parameter int SCREEN_COLS = twt_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = twt_pkg::DEF_SCREEN_ROWS,
  parameter int TAB_STOP    = twt_pkg::DEF_TAB_STOP
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  twt_pkg::twt_cfg_t             cfg,
  input  twt_pkg::twt_cmd_t             cmd,
  output twt_pkg::twt_status_t          status,
  input  logic [twt_pkg::OP_W-1:0]      in_operation,
  input  logic [twt_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [twt_pkg::ROW_W-1:0]     in_target_row,
  input  logic [twt_pkg::COL_W-1:0]     in_target_col,
  output logic [twt_pkg::CADDR_W-1:0]   out_cursor_address,
  output logic [twt_pkg::CHAR_W-1:0]    out_read_char
);
  import twt_pkg::*;

  localparam int NUM_CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W    = $clog2(NUM_CELLS);
  localparam int CA_W      = (ADDR_W > CADDR_W) ? ADDR_W : CADDR_W;
  localparam int TW_B      = $clog2(SCREEN_ROWS + 1);
  localparam int LW_B      = $clog2(SCREEN_COLS + 1);
  localparam int TW        = ((TW_B > ROW_W) ? TW_B : ROW_W) + 1;
  localparam int LW        = ((LW_B > COL_W) ? LW_B : COL_W) + 1;
  localparam logic [2**COL_W-1:0] TAB_MASK = tab_mask(TAB_STOP);

  function automatic logic [CA_W-1:0] cell_addr(input logic [TW-1:0]    top,
                                                input logic [LW-1:0]    left,
                                                input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    logic [CA_W-1:0] srow;
    srow = CA_W'(top) + CA_W'(r);
    return CA_W'(srow * CA_W'(SCREEN_COLS)) + CA_W'(left) + CA_W'(c);
  endfunction

  // screen store
  logic [CHAR_W-1:0] screen_mem [NUM_CELLS];
  logic [CHAR_W-1:0] mem_q_r;

  op_t               op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [ROW_W-1:0]  tr_r;
  logic [COL_W-1:0]  tc_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  sw_row_r;
  logic [COL_W-1:0]  sw_col_r;
  logic [ADDR_W-1:0] init_addr_r;
  logic [CHAR_W-1:0] rd_r;
  logic [CADDR_W-1:0] out_cursor_address_r;
  logic [CHAR_W-1:0]  out_read_char_r;

  // effective window geometry
  logic [TW-1:0]    g_top, room_r;
  logic [LW-1:0]    g_left, room_c;
  logic [COL_W-1:0] w0, g_w;
  logic [ROW_W-1:0] h0, g_h;

  always_comb begin
    g_top  = (TW'(cfg.top_row) < TW'(SCREEN_ROWS)) ? TW'(cfg.top_row) : TW'(SCREEN_ROWS - 1);
    g_left = (LW'(cfg.left_col) < LW'(SCREEN_COLS)) ? LW'(cfg.left_col)
                                                   : LW'(SCREEN_COLS - 1);
    w0     = (cfg.width == '0) ? COL_W'(1) : cfg.width;
    h0     = (cfg.height == '0) ? ROW_W'(1) : cfg.height;
    room_c = LW'(SCREEN_COLS) - g_left;
    room_r = TW'(SCREEN_ROWS) - g_top;
    g_w    = (LW'(w0) > room_c) ? room_c[COL_W-1:0] : w0;
    g_h    = (TW'(h0) > room_r) ? room_r[ROW_W-1:0] : h0;
  end

  logic [COL_W-1:0] col_inc;
  logic             col_ge;
  logic [ROW_W-1:0] row_after;
  logic             row_over;

  assign col_inc   = col_r + COL_W'(1);
  assign col_ge    = (col_r >= g_w);
  assign row_after = col_ge ? row_r + ROW_W'(1) : row_r;
  assign row_over  = (row_after >= g_h);

  // cursor
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.accept) begin
      if (op_t'(in_operation) == OP_PUT_AT) begin
        row_nxt = (in_target_row < g_h) ? in_target_row : g_h - ROW_W'(1);
        col_nxt = (in_target_col < g_w) ? in_target_col : g_w - COL_W'(1);
      end else begin
        row_nxt = (row_r < g_h) ? row_r : g_h - ROW_W'(1);
        col_nxt = (col_r < g_w) ? col_r : g_w - COL_W'(1);
      end
    end else begin
      case (cmd.cur_op)
        CUR_BACK: if (col_r != '0) col_nxt = col_r - COL_W'(1);
        CUR_NEWLINE: begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
        end
        CUR_ADVANCE: col_nxt = col_inc;
        CUR_WRAP: begin
          if (col_ge) col_nxt = '0;
          row_nxt = row_over ? g_h - ROW_W'(1) : row_after;
        end
        CUR_HOME: begin
          row_nxt = '0;
          col_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // store ports
  logic [CA_W-1:0]   cur_addr, sw_addr, tgt_addr, below_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata;

  assign cur_addr   = cell_addr(g_top, g_left, row_r, col_r);
  assign sw_addr    = cell_addr(g_top, g_left, sw_row_r, sw_col_r);
  assign tgt_addr   = cell_addr(g_top, g_left, tr_r, tc_r);
  assign below_addr = cell_addr(g_top, g_left, sw_row_r + ROW_W'(1), sw_col_r);

  always_comb begin
    mem_we    = cmd.wr_en || cmd.init_wr;
    mem_waddr = cmd.wr_at_sweep ? sw_addr[ADDR_W-1:0] : cur_addr[ADDR_W-1:0];
    case (cmd.wr_src)
      WSRC_CHAR:  mem_wdata = ch_r;
      WSRC_MEMQ:  mem_wdata = mem_q_r;
      default:    mem_wdata = BLANK_CHAR;
    endcase
    if (cmd.init_wr) begin
      mem_waddr = init_addr_r;
      mem_wdata = BLANK_CHAR;
    end
    mem_raddr = cmd.rd_at_target ? tgt_addr[ADDR_W-1:0] : below_addr[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) screen_mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_en) mem_q_r <= screen_mem[mem_raddr];
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_addr_r <= '0;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cmd.init_wr) init_addr_r <= init_addr_r + ADDR_W'(1);
    end
  end

  // item fields, sweep position and result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= op_t'(in_operation);
      ch_r <= in_char_code;
      tr_r <= in_target_row;
      tc_r <= in_target_col;
      rd_r <= '0;
    end
    if (cmd.rd_capture) rd_r <= mem_q_r;
    if (cmd.sweep_start) begin
      sw_row_r <= '0;
      sw_col_r <= '0;
    end else if (cmd.sweep_step) begin
      if (status.last_col) begin
        sw_col_r <= '0;
        sw_row_r <= sw_row_r + ROW_W'(1);
      end else begin
        sw_col_r <= sw_col_r + COL_W'(1);
      end
    end
    if (cmd.out_load) begin
      out_cursor_address_r <= cur_addr[CADDR_W-1:0];
      out_read_char_r      <= rd_r;
    end
  end

  always_comb begin
    status.op            = op_r;
    status.enabled       = cfg.enabled;
    if (ch_r == CODE_BS)                         status.ch_kind = CH_BS;
    else if (ch_r == CODE_TAB)                   status.ch_kind = CH_TAB;
    else if (ch_r == CODE_LF || ch_r == CODE_CR) status.ch_kind = CH_NL;
    else                                         status.ch_kind = CH_PRINT;
    status.tab_more      = !TAB_MASK[col_inc] && (col_inc < g_w);
    status.row_over      = row_over;
    status.one_row       = (g_h == ROW_W'(1));
    status.last_col      = (sw_col_r == g_w - COL_W'(1));
    status.last_copy_row = ((ROW_W + 1)'(sw_row_r) + (ROW_W + 1)'(2) == (ROW_W + 1)'(g_h));
    status.last_row      = (sw_row_r == g_h - ROW_W'(1));
    status.rd_in_window  = (tr_r < g_h) && (tc_r < g_w);
    status.init_last     = (init_addr_r == ADDR_W'(NUM_CELLS - 1));
  end

  assign out_cursor_address = out_cursor_address_r;
  assign out_read_char      = out_read_char_r;

endmodule

### design/text_window_terminal.sv
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------------
// input     | in_valid / in_stall  | in_operation, in_char_code, in_target_row/col
// result    | out_valid/out_stall  | out_cursor_address, out_read_char
// config    | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// a plain put runs the dispatch, char, wrap and done states from input transfer to result;
// a tab writes one blank per column up to the next tab stop; a scroll copies each window
// row above the bottom row up from the row below, one cell read and then written, and
// then blanks the bottom row. a window clear blanks the window one cell a cycle. one item
// is in flight at a time. after reset the store is swept to spaces, one cell a cycle, with
// in_stall high; config writes are taken meanwhile. a finished result waits in the output
// register while the next item is taken.
module text_window_terminal #(
  parameter int SCREEN_COLS = twt_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = twt_pkg::DEF_SCREEN_ROWS,
  parameter int TAB_STOP    = twt_pkg::DEF_TAB_STOP
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [twt_pkg::OP_W-1:0]      in_operation,
  input  logic [twt_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [twt_pkg::ROW_W-1:0]     in_target_row,
  input  logic [twt_pkg::COL_W-1:0]     in_target_col,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [twt_pkg::CADDR_W-1:0]   out_cursor_address,
  output logic [twt_pkg::CHAR_W-1:0]    out_read_char,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twt_pkg::PADDR_W-1:0]   paddr,
  input  logic [twt_pkg::DATA_W-1:0]    pwdata,
  output logic [twt_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import twt_pkg::*;

  twt_cfg_t    cfg_r;
  twt_cmd_t    cmd;
  twt_status_t status;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  // register file: word index from the byte address
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled  <= RST_ENABLED;
      cfg_r.top_row  <= RST_TOP;
      cfg_r.left_col <= RST_LEFT;
      cfg_r.width    <= RST_WIDTH;
      cfg_r.height   <= RST_HEIGHT;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ENABLED: cfg_r.enabled  <= pwdata[0];
        REG_TOP:     cfg_r.top_row  <= pwdata[ROW_W-1:0];
        REG_LEFT:    cfg_r.left_col <= pwdata[COL_W-1:0];
        REG_WIDTH:   cfg_r.width    <= pwdata[COL_W-1:0];
        REG_HEIGHT:  cfg_r.height   <= pwdata[ROW_W-1:0];
        default:     ;  // unmapped addresses ignore the transfer
      endcase
    end
  end

  // read back the raw register values
  always_comb begin
    case (reg_idx)
      REG_ENABLED: prdata = DATA_W'(cfg_r.enabled);
      REG_TOP:     prdata = DATA_W'(cfg_r.top_row);
      REG_LEFT:    prdata = DATA_W'(cfg_r.left_col);
      REG_WIDTH:   prdata = DATA_W'(cfg_r.width);
      REG_HEIGHT:  prdata = DATA_W'(cfg_r.height);
      default:     prdata = '0;
    endcase
  end

  // sequencer: init sweep, dispatch, tab loop, scroll and clear sweeps, read and result
  twt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // cursor, window geometry, screen store and result registers
  twt_dp #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .TAB_STOP    (TAB_STOP)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .cmd                (cmd),
    .status             (status),
    .in_operation       (in_operation),
    .in_char_code       (in_char_code),
    .in_target_row      (in_target_row),
    .in_target_col      (in_target_col),
    .out_cursor_address (out_cursor_address),
    .out_read_char      (out_read_char)
  );

  // an accepted item keeps the input side closed in the next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after a transfer");

  // a result only appears at the end of an item in flight
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an item in flight");

  // the store sweep keeps the input closed right after reset
  a_closed_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_stall)
    else $error("input open during store sweep");

  // a stalled result stays offered with an unchanged payload
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_cursor_address)
                                  && $stable(out_read_char)))
    else $error("stalled result changed");

endmodule
